[sv/urh_pkg.sv]
// urh_pkg: shared constants, command codes and status type for the undo/redo
// history ring. No dependencies; imported by urh_ctrl and the top level.
package urh_pkg;

	// Default geometry
	localparam int DEPTH_DEF     = 256;
	localparam int SNAP_BITS_DEF = 64;

	// Fixed field widths
	localparam int FUNC_W = 3;
	localparam int IDX_W  = 8;
	localparam int CFG_W  = 8;
	localparam int CFGA_W = 2;

	// Command codes
	localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd0;
	localparam logic [FUNC_W-1:0] FN_TICK  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_FORCE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_UNDO  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REDO  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_READ  = 3'd5;

	// Configuration register indexes
	localparam logic [CFGA_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFGA_W-1:0] REG_MAX_UNDO = 2'd1;
	localparam logic [CFGA_W-1:0] REG_LIMIT_EN = 2'd2;

	// Configuration reset values
	localparam logic [CFG_W-1:0] INTERVAL_RST = 8'd1;
	localparam logic [CFG_W-1:0] MAX_UNDO_RST = 8'd255;

	// Per-command status from control to the result stage
	typedef struct packed {
		logic ok;
		logic from_mem;
		logic undo_possible;
		logic redo_possible;
	} stat_t;

endpackage

[sv/undo_redo_history_ring_unit.sv]
// undo_redo_history_ring_unit: top level of the undo/redo history ring.
// Depends on urh_pkg, urh_ctrl and urh_ram.
//
// Takes one command per clock: busy stays low, a beat is taken whenever start
// is high, and its result shows on the outputs with done high for exactly one
// cycle, in the cycle after the one that accepted it. The receiver cannot hold
// results off, and none is needed: a new beat each cycle gives a new result each
// cycle. The result is registered alongside the registered read port of the
// history memory, which undo, redo and read commands go through.
// Configuration writes take effect at the edge where cfg_we is high and must
// only be issued while no result is pending.
module undo_redo_history_ring_unit #(
	parameter int DEPTH     = urh_pkg::DEPTH_DEF,
	parameter int SNAP_BITS = urh_pkg::SNAP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [urh_pkg::FUNC_W-1:0]    func,
	input  logic [SNAP_BITS-1:0]          snapshot,
	input  logic [urh_pkg::IDX_W-1:0]     index,
	input  logic                          cfg_we,
	input  logic [urh_pkg::CFGA_W-1:0]    cfg_index,
	input  logic [urh_pkg::CFG_W-1:0]     cfg_data,
	output logic                          done,
	output logic                          ok,
	output logic [SNAP_BITS-1:0]          data,
	output logic [$clog2(DEPTH+1)-1:0]    entry_count,
	output logic [$clog2(DEPTH)-1:0]      cursor_pos,
	output logic                          undo_possible,
	output logic                          redo_possible
);
	import urh_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                 cmd_go;
	logic                 wr_en, rd_en;
	logic [PTR_W-1:0]     wr_addr, rd_addr;
	logic [SNAP_BITS-1:0] wr_data, rd_data;
	stat_t                stat;
	logic [CNT_W-1:0]     cnt_nx;
	logic [PTR_W-1:0]     cur_nx;

	logic                 done_s1;
	logic                 ok_s1, from_mem_s1, undo_s1, redo_s1;
	logic [SNAP_BITS-1:0] data_s1;
	logic [CNT_W-1:0]     cnt_s1;
	logic [PTR_W-1:0]     cur_s1;

	// busy is tied low, so start alone accepts a beat
	assign busy   = 1'b0;
	assign cmd_go = start & ~busy;

	urh_ctrl #(
		.DEPTH     (DEPTH),
		.SNAP_BITS (SNAP_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_go    (cmd_go),
		.func      (func),
		.snapshot  (snapshot),
		.index     (index),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.stat      (stat),
		.cnt_nx    (cnt_nx),
		.cur_nx    (cur_nx)
	);

	urh_ram #(
		.DEPTH     (DEPTH),
		.SNAP_BITS (SNAP_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= cmd_go;
		end
	end

	// result payload, alongside the memory read
	always_ff @(posedge clk) begin
		if (cmd_go) begin
			ok_s1       <= stat.ok;
			from_mem_s1 <= stat.from_mem;
			undo_s1     <= stat.undo_possible;
			redo_s1     <= stat.redo_possible;
			cnt_s1      <= cnt_nx;
			cur_s1      <= cur_nx;
			data_s1     <= (stat.ok && !stat.from_mem) ? snapshot : '0;
		end
	end

	assign done          = done_s1;
	assign ok            = ok_s1;
	assign data          = from_mem_s1 ? rd_data : data_s1;
	assign entry_count   = cnt_s1;
	assign cursor_pos    = cur_s1;
	assign undo_possible = undo_s1;
	assign redo_possible = redo_s1;

endmodule

[sv/urh_ram.sv]
// urh_ram: simple dual-port history store, one write and one registered read
// per cycle. Depends on nothing.
module urh_ram #(
	parameter int DEPTH     = 256,
	parameter int SNAP_BITS = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [SNAP_BITS-1:0]     wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [SNAP_BITS-1:0]     rd_data
);
	logic [SNAP_BITS-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/urh_ctrl.sv]
// urh_ctrl: configuration registers, ring pointers, cursor and tick counter;
// decodes one command per cycle into memory accesses and next state.
// Depends on urh_pkg.
module urh_ctrl #(
	parameter int DEPTH     = 256,
	parameter int SNAP_BITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_go,
	input  logic [urh_pkg::FUNC_W-1:0]    func,
	input  logic [SNAP_BITS-1:0]          snapshot,
	input  logic [urh_pkg::IDX_W-1:0]     index,
	input  logic                          cfg_we,
	input  logic [urh_pkg::CFGA_W-1:0]    cfg_index,
	input  logic [urh_pkg::CFG_W-1:0]     cfg_data,
	output logic                          wr_en,
	output logic [$clog2(DEPTH)-1:0]      wr_addr,
	output logic [SNAP_BITS-1:0]          wr_data,
	output logic                          rd_en,
	output logic [$clog2(DEPTH)-1:0]      rd_addr,
	output urh_pkg::stat_t                stat,
	output logic [$clog2(DEPTH+1)-1:0]    cnt_nx,
	output logic [$clog2(DEPTH)-1:0]      cur_nx
);
	import urh_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > CFG_W + 1) ? CNT_W : CFG_W + 1;

	// ring offset add, operands below DEPTH so one subtract wraps it
	function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] a,
		input logic [CW-1:0] b);
		logic [CW:0] sum;
		begin
			sum = (CW+1)'(a) + (CW+1)'(b);
			if (sum >= (CW+1)'(DEPTH)) begin
				sum = sum - (CW+1)'(DEPTH);
			end
			slot_add = sum[PTR_W-1:0];
		end
	endfunction

	// lowest cursor position undo may reach
	function automatic logic [CW-1:0] low_pos(input logic [CW-1:0] c, input logic lim,
		input logic [CFG_W-1:0] m);
		logic [CW-1:0] mw;
		begin
			mw = CW'(m);
			if (c == '0 || !lim) begin
				low_pos = '0;
			end else if (c - CW'(1) <= mw) begin
				low_pos = '0;
			end else begin
				low_pos = c - CW'(1) - mw;
			end
		end
	endfunction

	logic [CFG_W-1:0] interval_q;
	logic [CFG_W-1:0] max_undo_q;
	logic             limit_q;
	logic [PTR_W-1:0] optr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] cur_q;
	logic [CFG_W-1:0] tick_q;

	logic [CW-1:0]    cnt_w, cur_w, low_w, keep_w;
	logic [CW-1:0]    trunc_cnt, cnt_a, cnt_b;
	logic [PTR_W-1:0] optr_a, optr_b, rec_slot;
	logic [CFG_W-1:0] tick_inc;
	logic             tick_due;
	logic             store;
	logic [PTR_W-1:0] optr_n;
	logic [CW-1:0]    cnt_n, cur_n, low_n;
	logic [CFG_W-1:0] tick_n;
	logic             ok, from_mem;
	logic [PTR_W-1:0] rslot;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			max_undo_q <= MAX_UNDO_RST;
			limit_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL: interval_q <= cfg_data;
				REG_MAX_UNDO: max_undo_q <= cfg_data;
				REG_LIMIT_EN: limit_q    <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	assign cnt_w  = CW'(cnt_q);
	assign cur_w  = CW'(cur_q);
	assign low_w  = low_pos(cnt_w, limit_q, max_undo_q);
	assign keep_w = CW'(max_undo_q) + CW'(1);

	// record path: drop redo tail, make room, append, apply limit
	always_comb begin
		if (cnt_w != '0 && cur_w + CW'(1) < cnt_w) begin
			trunc_cnt = cur_w + CW'(1);
		end else begin
			trunc_cnt = cnt_w;
		end
		if (trunc_cnt >= CW'(DEPTH)) begin
			optr_a = slot_add(optr_q, CW'(1));
			cnt_a  = CW'(DEPTH - 1);
		end else begin
			optr_a = optr_q;
			cnt_a  = trunc_cnt;
		end
		rec_slot = slot_add(optr_a, cnt_a);
		cnt_b    = cnt_a + CW'(1);
		optr_b   = optr_a;
		if (limit_q && cnt_b > keep_w) begin
			optr_b = slot_add(optr_a, cnt_b - keep_w);
			cnt_b  = keep_w;
		end
	end

	assign tick_inc = tick_q + CFG_W'(1);
	assign tick_due = tick_inc >= interval_q;

	// command decode
	always_comb begin
		optr_n   = optr_q;
		cnt_n    = cnt_w;
		cur_n    = cur_w;
		tick_n   = tick_q;
		store    = 1'b0;
		ok       = 1'b0;
		from_mem = 1'b0;
		rslot    = optr_q;
		case (func)
			FN_CLEAR: begin
				optr_n = '0;
				cnt_n  = '0;
				cur_n  = '0;
				tick_n = '0;
			end
			FN_TICK: begin
				tick_n = tick_inc;
				if (tick_due) begin
					tick_n = '0;
					store  = 1'b1;
				end
			end
			FN_FORCE: begin
				tick_n = '0;
				store  = 1'b1;
			end
			FN_UNDO: begin
				if (cur_w > low_w) begin
					cur_n    = cur_w - CW'(1);
					ok       = 1'b1;
					from_mem = 1'b1;
					rslot    = slot_add(optr_q, cur_w - CW'(1));
				end
			end
			FN_REDO: begin
				if (cnt_w != '0 && cur_w + CW'(1) < cnt_w) begin
					cur_n    = cur_w + CW'(1);
					ok       = 1'b1;
					from_mem = 1'b1;
					rslot    = slot_add(optr_q, cur_w + CW'(1));
				end
			end
			FN_READ: begin
				if (CW'(index) < cnt_w) begin
					ok       = 1'b1;
					from_mem = 1'b1;
					rslot    = slot_add(optr_q, CW'(index));
				end
			end
			default: ;
		endcase
		if (store) begin
			optr_n = optr_b;
			cnt_n  = cnt_b;
			cur_n  = cnt_b - CW'(1);
			ok     = 1'b1;
		end
	end

	// status seen after the command
	assign low_n = low_pos(cnt_n, limit_q, max_undo_q);
	always_comb begin
		stat.ok            = ok;
		stat.from_mem      = from_mem;
		stat.undo_possible = cur_n > low_n;
		stat.redo_possible = (cnt_n != '0) && (cur_n + CW'(1) < cnt_n);
	end

	assign cnt_nx  = cnt_n[CNT_W-1:0];
	assign cur_nx  = cur_n[PTR_W-1:0];
	assign wr_en   = cmd_go & store;
	assign wr_addr = rec_slot;
	assign wr_data = snapshot;
	assign rd_en   = cmd_go & from_mem;
	assign rd_addr = rslot;

	// state update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			optr_q <= '0;
			cnt_q  <= '0;
			cur_q  <= '0;
			tick_q <= '0;
		end else if (cmd_go) begin
			optr_q <= optr_n;
			cnt_q  <= cnt_n[CNT_W-1:0];
			cur_q  <= cur_n[PTR_W-1:0];
			tick_q <= tick_n;
		end
	end

endmodule
